// ===== src/swas_pkg.sv =====
// ----------------------------------------------------------------------------
// swas_pkg
// Shared types and codes for the sliding window anagram search block.
// ----------------------------------------------------------------------------
package swas_pkg;

	localparam int ALPHABET_SIZE_DEF = 256;
	localparam int MAX_PATTERN_DEF   = 256;

	localparam logic [1:0] FUNC_PATTERN = 2'd0;
	localparam logic [1:0] FUNC_TEXT    = 2'd1;
	localparam logic [1:0] FUNC_CLEAR   = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_LATE     = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] symbol;
	} item_t;

	typedef struct packed {
		logic       match_now;
		logic       found_so_far;
		logic       window_full;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic clear;
		logic rd_en;
		logic wr_en;
	} hist_cmd_t;

endpackage

// ===== src/sliding_window_anagram_search.sv =====
// ----------------------------------------------------------------------------
// sliding_window_anagram_search
// Reports for each text byte whether the last pattern-length bytes are a
// permutation of the loaded pattern.
//
//   channel   signals                        payload
//   item      item_valid / item_ready        item   (func, symbol)
//   result    result_valid / result_ready    result (match_now, found_so_far,
//                                                    window_full, status)
//
// A pattern byte or a text byte while the window fills passes IDLE, RD1 and
// FIN; a text byte on a full window adds RD2 after RD1; clear, ignored bytes
// and text on an empty pattern go from IDLE to FIN. The path is set by the
// read-modify-write chain on the single histogram port; items are taken in IDLE.
// Reset and clear empty the histograms at once through per-entry valid bits.
// A result waiting on result_ready holds the next item in its last cycle.
// ----------------------------------------------------------------------------
module sliding_window_anagram_search #(
	parameter int ALPHABET_SIZE = swas_pkg::ALPHABET_SIZE_DEF,
	parameter int MAX_PATTERN   = swas_pkg::MAX_PATTERN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  swas_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output swas_pkg::result_t result
);

	localparam int AW  = $clog2(ALPHABET_SIZE);
	localparam int CW  = $clog2(MAX_PATTERN + 1);
	localparam int DW  = $clog2(ALPHABET_SIZE + 1);
	localparam int RPW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int EW  = 2 * CW;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD1  = 2'd1;
	localparam logic [1:0] ST_RD2  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_PAT   = 3'd1;
	localparam logic [2:0] OP_ADD   = 3'd2;
	localparam logic [2:0] OP_SLIDE = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;
	localparam logic [2:0] OP_EMPTY = 3'd5;

	logic [1:0]     state_q;
	logic [2:0]     op_q;
	logic [1:0]     status_q;
	logic [AW-1:0]  sym_q;
	logic [AW-1:0]  gone_q;
	logic [EW-1:0]  symrd_q;
	logic [EW-1:0]  ent_q;
	logic           up_q;
	logic           dn_q;

	logic [CW-1:0]  plen_q;
	logic [CW-1:0]  filled_q;
	logic [RPW-1:0] ptr_q;
	logic [DW-1:0]  diff_q;
	logic           found_q;

	logic           res_valid_q;
	swas_pkg::result_t res_q;

	logic           accept;
	logic           fin_go;
	logic [AW-1:0]  sym_c;
	logic [2:0]     op_c;
	logic [1:0]     status_c;

	swas_pkg::hist_cmd_t hcmd;
	logic [AW-1:0]  hrd_addr;
	logic [EW-1:0]  hrd_data;
	logic [AW-1:0]  hwr_addr;
	logic [EW-1:0]  hwr_data;
	logic           ring_wr;
	logic [AW-1:0]  ring_rdata;

	logic [CW-1:0]  g_p, g_w, mid_w;
	logic           g_before, g_after;
	logic [EW-1:0]  mid;
	logic [EW-1:0]  inc_src, inc_new;
	logic [CW-1:0]  src_p, src_w, new_p, new_w;

	logic [CW-1:0]  plen_n, filled_n;
	logic [RPW-1:0] ptr_n;
	logic [DW-1:0]  diff_n, diff_dec;
	logic           found_n, full_n;
	logic [CW:0]    ptr_inc;

	assign accept     = item_valid && item_ready;
	assign item_ready = (state_q == ST_IDLE);
	assign fin_go     = (state_q == ST_FIN) && (!res_valid_q || result_ready);

	assign sym_c = ({1'b0, item.symbol} >= 9'(ALPHABET_SIZE)) ?
		AW'(ALPHABET_SIZE - 1) : item.symbol[AW-1:0];

	always_comb begin
		op_c     = OP_NONE;
		status_c = swas_pkg::STATUS_OK;
		unique case (item.func)
			swas_pkg::FUNC_CLEAR: begin
				op_c = OP_CLEAR;
			end
			swas_pkg::FUNC_PATTERN: begin
				priority if (filled_q != '0) begin
					status_c = swas_pkg::STATUS_LATE;
				end else if (plen_q >= CW'(MAX_PATTERN)) begin
					status_c = swas_pkg::STATUS_OVERFLOW;
				end else begin
					op_c = OP_PAT;
				end
			end
			swas_pkg::FUNC_TEXT: begin
				priority if (plen_q == '0) begin
					op_c = OP_EMPTY;
				end else if (filled_q >= plen_q) begin
					op_c = OP_SLIDE;
				end else begin
					op_c = OP_ADD;
				end
			end
			default: begin
				op_c = OP_NONE;
			end
		endcase
	end

	// outgoing symbol: saturating window decrement
	assign g_p      = hrd_data[EW-1:CW];
	assign g_w      = hrd_data[CW-1:0];
	assign mid_w    = (g_w != '0) ? g_w - CW'(1) : g_w;
	assign mid      = {g_p, mid_w};
	assign g_before = (g_p != g_w);
	assign g_after  = (g_p != mid_w);
	assign diff_dec = (g_before && !g_after && diff_q != '0) ? diff_q - DW'(1) :
		(!g_before && g_after) ? diff_q + DW'(1) : diff_q;

	// incoming symbol, forwarded from the decrement when both hit one entry
	assign inc_src = (state_q == ST_RD2) ? ((gone_q == sym_q) ? mid : symrd_q) : hrd_data;
	assign src_p   = inc_src[EW-1:CW];
	assign src_w   = inc_src[CW-1:0];
	assign new_p   = (op_q == OP_PAT) ? src_p + CW'(1) : src_p;
	assign new_w   = (op_q == OP_PAT) ? src_w : src_w + CW'(1);
	assign inc_new = {new_p, new_w};

	always_comb begin
		hcmd.clear = fin_go && (op_q == OP_CLEAR);
		hcmd.rd_en = accept || (state_q == ST_RD1 && op_q == OP_SLIDE);
		hcmd.wr_en = (state_q == ST_RD2) ||
			(fin_go && (op_q == OP_PAT || op_q == OP_ADD || op_q == OP_SLIDE));
		hrd_addr   = (state_q == ST_IDLE) ? sym_c : ring_rdata;
		hwr_addr   = (state_q == ST_RD2) ? gone_q : sym_q;
		hwr_data   = (state_q == ST_RD2) ? mid : ent_q;
	end

	assign ring_wr = fin_go && (op_q == OP_ADD || op_q == OP_SLIDE);

	swas_hist #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.EW           (EW)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (hcmd),
		.rd_addr(hrd_addr),
		.rd_data(hrd_data),
		.wr_addr(hwr_addr),
		.wr_data(hwr_data)
	);

	swas_ram #(
		.WIDTH(AW),
		.DEPTH(MAX_PATTERN)
	) u_ring (
		.clk    (clk),
		.wr_en  (ring_wr),
		.wr_addr(ptr_q),
		.wr_data(sym_q),
		.rd_en  (accept),
		.rd_addr(ptr_q),
		.rd_data(ring_rdata)
	);

	assign ptr_inc = (CW + 1)'(ptr_q) + (CW + 1)'(1);

	always_comb begin
		plen_n   = plen_q;
		filled_n = filled_q;
		ptr_n    = ptr_q;
		diff_n   = diff_q;
		found_n  = found_q;
		if (dn_q && diff_q != '0) begin
			diff_n = diff_q - DW'(1);
		end else if (up_q) begin
			diff_n = diff_q + DW'(1);
		end
		unique case (op_q)
			OP_CLEAR: begin
				plen_n   = '0;
				filled_n = '0;
				ptr_n    = '0;
				diff_n   = '0;
				found_n  = 1'b0;
			end
			OP_PAT: begin
				plen_n = plen_q + CW'(1);
			end
			OP_ADD, OP_SLIDE: begin
				ptr_n = (ptr_inc >= {1'b0, plen_q}) ? '0 : ptr_inc[RPW-1:0];
				if (filled_q < plen_q) begin
					filled_n = filled_q + CW'(1);
				end
			end
			OP_EMPTY: begin
				filled_n = CW'(1);
				diff_n   = diff_q;
			end
			default: begin
				diff_n = diff_q;
			end
		endcase
		full_n = (filled_n != '0) && (filled_n >= plen_n);
		if ((op_q == OP_ADD || op_q == OP_SLIDE || op_q == OP_EMPTY) &&
			full_n && diff_n == '0) begin
			found_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			plen_q      <= '0;
			filled_q    <= '0;
			ptr_q       <= '0;
			diff_q      <= '0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (op_c == OP_PAT || op_c == OP_ADD || op_c == OP_SLIDE) ?
							ST_RD1 : ST_FIN;
					end
				end
				ST_RD1: begin
					state_q <= (op_q == OP_SLIDE) ? ST_RD2 : ST_FIN;
				end
				ST_RD2: begin
					diff_q  <= diff_dec;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						plen_q   <= plen_n;
						filled_q <= filled_n;
						ptr_q    <= ptr_n;
						diff_q   <= diff_n;
						found_q  <= found_n;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fin_go) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_c;
			status_q <= status_c;
			sym_q    <= sym_c;
			up_q     <= 1'b0;
			dn_q     <= 1'b0;
		end
		if (state_q == ST_RD1) begin
			symrd_q <= hrd_data;
			gone_q  <= ring_rdata;
		end
		if ((state_q == ST_RD1 && op_q != OP_SLIDE) || state_q == ST_RD2) begin
			ent_q <= inc_new;
			up_q  <= (src_p == src_w) && (new_p != new_w);
			dn_q  <= (src_p != src_w) && (new_p == new_w);
		end
		if (fin_go) begin
			res_q.match_now    <= full_n && (diff_n == '0);
			res_q.found_so_far <= found_n;
			res_q.window_full  <= full_n;
			res_q.status       <= status_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(hcmd.wr_en && hcmd.rd_en))
		else $error("histogram read and write in one cycle");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(plen_q == '0) || ((CW + 1)'(ptr_q) < {1'b0, plen_q}))
		else $error("ring pointer beyond pattern length");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(filled_q <= plen_q) || (filled_q == CW'(1)))
		else $error("text fill beyond window");

	a_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(found_q) |-> $past(fin_go && op_q == OP_CLEAR))
		else $error("found flag dropped without clear");

	a_diff_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((DW + 1)'(diff_q) <= (DW + 1)'(ALPHABET_SIZE)))
		else $error("differing symbol count out of range");

endmodule

// ===== src/swas_ram.sv =====
// ----------------------------------------------------------------------------
// swas_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/swas_hist.sv =====
// ----------------------------------------------------------------------------
// swas_hist
// Histogram store: pattern and window counts per symbol in one RAM, with
// per-entry valid bits so that clear takes effect at once.
// ----------------------------------------------------------------------------
module swas_hist #(
	parameter int ALPHABET_SIZE = swas_pkg::ALPHABET_SIZE_DEF,
	parameter int EW            = 18,
	localparam int AW           = $clog2(ALPHABET_SIZE)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swas_pkg::hist_cmd_t  cmd,
	input  logic [AW-1:0]        rd_addr,
	output logic [EW-1:0]        rd_data,
	input  logic [AW-1:0]        wr_addr,
	input  logic [EW-1:0]        wr_data
);

	logic [ALPHABET_SIZE-1:0] vld_q;
	logic                     vld_rd_q;
	logic [EW-1:0]            ram_data;

	swas_ram #(
		.WIDTH(EW),
		.DEPTH(ALPHABET_SIZE)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (cmd.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				vld_rd_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = vld_rd_q ? ram_data : '0;

endmodule

// ===== sim/anagram_match_checker.sv =====
// ----------------------------------------------------------------------------
// anagram_match_checker
// Watches the item and result channels of the anagram search block. It keeps
// its own pattern and window histograms, text ring and match bookkeeping,
// predicts one result per item transfer and compares each result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module anagram_match_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  swas_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  swas_pkg::result_t result,
	output int unsigned       mismatches,
	output int unsigned       outstanding
);

	logic [8:0] pat_hist [swas_pkg::ALPHABET_SIZE_DEF];
	logic [8:0] win_hist [swas_pkg::ALPHABET_SIZE_DEF];
	logic [7:0] ring [swas_pkg::MAX_PATTERN_DEF];
	logic [8:0] pat_len;
	logic [8:0] text_seen;
	logic [7:0] ring_ptr;
	logic [8:0] diff_syms;
	logic       found;

	swas_pkg::result_t expected_results [$];

	function automatic void clear_state();
		foreach (pat_hist[i]) begin
			pat_hist[i] = '0;
			win_hist[i] = '0;
		end
		foreach (ring[i]) ring[i] = '0;
		pat_len   = '0;
		text_seen = '0;
		ring_ptr  = '0;
		diff_syms = '0;
		found     = 1'b0;
	endfunction

	// keeps diff_syms in step with every histogram change
	function automatic void bump_count(input bit in_window, input logic [7:0] sym, input bit up);
		bit was_diff;
		bit now_diff;
		was_diff = pat_hist[sym] != win_hist[sym];
		if (in_window) begin
			if (up)
				win_hist[sym] = win_hist[sym] + 9'd1;
			else if (win_hist[sym] != 0)
				win_hist[sym] = win_hist[sym] - 9'd1;
		end else begin
			if (up)
				pat_hist[sym] = pat_hist[sym] + 9'd1;
			else if (pat_hist[sym] != 0)
				pat_hist[sym] = pat_hist[sym] - 9'd1;
		end
		now_diff = pat_hist[sym] != win_hist[sym];
		if (was_diff && !now_diff && diff_syms != 0)
			diff_syms = diff_syms - 9'd1;
		else if (!was_diff && now_diff)
			diff_syms = diff_syms + 9'd1;
	endfunction

	function automatic bit window_is_full();
		return text_seen != 0 && text_seen >= pat_len;
	endfunction

	function automatic swas_pkg::result_t predict_window_result(input swas_pkg::item_t it);
		swas_pkg::result_t r;
		int slot;
		r = '0;
		r.status = swas_pkg::STATUS_OK;
		unique case (it.func)
			swas_pkg::FUNC_CLEAR: begin
				clear_state();
			end
			swas_pkg::FUNC_PATTERN: begin
				if (text_seen != 0) begin
					r.status = swas_pkg::STATUS_LATE;
				end else if (pat_len >= swas_pkg::MAX_PATTERN_DEF) begin
					r.status = swas_pkg::STATUS_OVERFLOW;
				end else begin
					bump_count(1'b0, it.symbol, 1'b1);
					pat_len = pat_len + 9'd1;
				end
			end
			swas_pkg::FUNC_TEXT: begin
				if (pat_len == 0) begin
					text_seen = 9'd1;
				end else begin
					slot = ring_ptr;
					if (text_seen >= pat_len)
						bump_count(1'b1, ring[slot], 1'b0);
					bump_count(1'b1, it.symbol, 1'b1);
					ring[slot] = it.symbol;
					slot++;
					if (slot >= pat_len)
						slot = 0;
					ring_ptr = 8'(slot);
					if (text_seen < pat_len)
						text_seen = text_seen + 9'd1;
				end
				if (window_is_full() && diff_syms == 0)
					found = 1'b1;
			end
			default: begin
			end
		endcase
		r.window_full  = window_is_full();
		r.match_now    = window_is_full() && diff_syms == 0;
		r.found_so_far = found;
		return r;
	endfunction

	initial begin
		mismatches  = 0;
		outstanding = 0;
		clear_state();
	end

	always @(posedge clk) begin : monitor
		swas_pkg::result_t want;
		if (!arst_n) begin
			clear_state();
			expected_results.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: %p", result);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (result.match_now !== want.match_now) begin
						$error("match_now: expected %0d, got %0d", want.match_now,
							result.match_now);
						mismatches++;
					end
					if (result.found_so_far !== want.found_so_far) begin
						$error("found_so_far: expected %0d, got %0d", want.found_so_far,
							result.found_so_far);
						mismatches++;
					end
					if (result.window_full !== want.window_full) begin
						$error("window_full: expected %0d, got %0d", want.window_full,
							result.window_full);
						mismatches++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						mismatches++;
					end
				end
			end
			if (item_valid && item_ready)
				expected_results = {expected_results, predict_window_result(item)};
		end
		outstanding = expected_results.size();
	end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the anagram search block with a directed opening (empty pattern,
// late and unused codes, clears, byte extremes, a full-size pattern with
// overflow) and then random clear/pattern/text sequences with planted
// permutations and noise, under random idling on both channels. A separate
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

	localparam int ITEM_TARGET   = 1700;
	localparam int CALM_TAIL     = 150;
	localparam int STALL_LIMIT   = 4000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int BIG_SEQ_ITEMS = 2 * swas_pkg::MAX_PATTERN_DEF + 100;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	swas_pkg::item_t   item;
	logic              result_valid;
	logic              result_ready;
	swas_pkg::result_t result;
	int unsigned       mismatches;
	int unsigned       outstanding;
	int unsigned       items_sent;
	int unsigned       idle_pct;

	sliding_window_anagram_search u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	anagram_match_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send(input logic [1:0] f_code, input logic [7:0] sym);
		int unsigned gap;
		if (items_sent + CALM_TAIL >= ITEM_TARGET)
			idle_pct = 0;
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			gap = $urandom_range(1, 16);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{func: f_code, symbol: sym};
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// optionally clear, load a pattern, then stream text built mostly from the pattern's
	// letters with shuffled copies of the pattern planted in it
	task automatic run_sequence(input int plen, input int text_len, input bit do_clear);
		logic [7:0] letters [4];
		logic [7:0] pat [$];
		logic [7:0] perm [$];
		logic [7:0] tmp;
		int         n_letters;
		int         j;
		int         plant_pct;
		foreach (letters[i]) letters[i] = 8'($urandom_range(0, 255));
		n_letters = $urandom_range(2, 4);
		plant_pct = (plen <= 32) ? 5 : 0;
		if (items_sent + CALM_TAIL < ITEM_TARGET) begin
			case ($urandom_range(0, 3))
				0: idle_pct = 0;
				1: idle_pct = 5;
				2: idle_pct = 20;
				default: idle_pct = 50;
			endcase
		end
		if (do_clear)
			send(swas_pkg::FUNC_CLEAR, 8'($urandom));
		for (int i = 0; i < plen; i++) begin
			pat = {pat, letters[$urandom_range(0, n_letters - 1)]};
			send(swas_pkg::FUNC_PATTERN, pat[i]);
		end
		if (plen == swas_pkg::MAX_PATTERN_DEF) begin
			repeat ($urandom_range(1, 3)) send(swas_pkg::FUNC_PATTERN, 8'($urandom));
		end
		for (int i = 0; i < text_len; i++) begin
			if (i == text_len / 2 || $urandom_range(1, 100) <= plant_pct) begin
				perm = pat;
				for (int k = perm.size() - 1; k > 0; k--) begin
					j = $urandom_range(0, k);
					tmp = perm[k];
					perm[k] = perm[j];
					perm[j] = tmp;
				end
				foreach (perm[k]) send(swas_pkg::FUNC_TEXT, perm[k]);
			end else if ($urandom_range(1, 100) <= 5) begin
				send(2'($urandom_range(0, 3)), 8'($urandom));
			end else if ($urandom_range(1, 100) <= 10) begin
				send(swas_pkg::FUNC_TEXT, 8'($urandom));
			end else begin
				send(swas_pkg::FUNC_TEXT, letters[$urandom_range(0, n_letters - 1)]);
			end
		end
	endtask

	initial begin : result_sink
		int unsigned hold;
		hold = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				hold--;
			end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
				hold = $urandom_range(0, 15);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		int r;
		int plen;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		items_sent = 0;
		idle_pct   = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty pattern: first text byte fills and matches
		send(swas_pkg::FUNC_TEXT, 8'h00);
		send(FUNC_UNUSED, 8'hFF);
		send(swas_pkg::FUNC_PATTERN, 8'h41);
		send(swas_pkg::FUNC_CLEAR, 8'h00);
		send(swas_pkg::FUNC_PATTERN, 8'h00);
		send(swas_pkg::FUNC_PATTERN, 8'hFF);
		send(FUNC_UNUSED, 8'h5A);
		send(swas_pkg::FUNC_TEXT, 8'hFF);
		send(swas_pkg::FUNC_TEXT, 8'h00);
		send(swas_pkg::FUNC_TEXT, 8'h00);
		send(swas_pkg::FUNC_TEXT, 8'hFF);
		send(swas_pkg::FUNC_TEXT, 8'h55);
		send(swas_pkg::FUNC_PATTERN, 8'hAA);
		send(swas_pkg::FUNC_CLEAR, 8'hFF);
		send(swas_pkg::FUNC_PATTERN, 8'h80);
		send(swas_pkg::FUNC_TEXT, 8'h7F);
		send(swas_pkg::FUNC_TEXT, 8'h80);
		send(swas_pkg::FUNC_CLEAR, 8'h33);
		send(FUNC_UNUSED, 8'hCC);
		// full-size pattern, overflow bytes, window wrapping at full size
		run_sequence(swas_pkg::MAX_PATTERN_DEF, 6, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(1, 100);
			if (r <= 10)
				plen = 0;
			else if (r <= 70)
				plen = $urandom_range(1, 8);
			else if (r <= 95 || items_sent + BIG_SEQ_ITEMS >= ITEM_TARGET)
				plen = $urandom_range(9, 32);
			else
				plen = $urandom_range(33, swas_pkg::MAX_PATTERN_DEF);
			run_sequence(plen, $urandom_range(8, 40), $urandom_range(1, 10) != 1);
		end
		item_valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
